### design/bdu_pkg.sv
// ----------------------------------------------------------------------------
// Bilinear 2x upscaler package
// Shared widths, parameter defaults and configuration register indexes.
// ----------------------------------------------------------------------------
package bdu_pkg;

    localparam int CFG_W              = 11;
    localparam int COORD_W            = 11;
    localparam int CFG_INDEX_W        = 1;

    localparam int DEF_MAX_WIDTH      = 1024;
    localparam int DEF_MAX_HEIGHT     = 1024;
    localparam int DEF_PIXEL_BITS     = 16;

    localparam int RESET_FRAME_WIDTH  = 640;
    localparam int RESET_FRAME_HEIGHT = 480;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

endpackage

### design/bdu_pixel_if.sv
// ----------------------------------------------------------------------------
// Source pixel channel
// Valid/ready channel carrying one source pixel and its frame start flag.
// ----------------------------------------------------------------------------
interface bdu_pixel_if
    import bdu_pkg::*;
#(
    parameter int PIXEL_BITS = DEF_PIXEL_BITS
);
    logic                  valid;
    logic                  ready;
    logic [PIXEL_BITS-1:0] pixel_value;
    logic                  start_of_frame;

    modport source (output valid, output pixel_value, output start_of_frame, input ready);
    modport sink   (input valid, input pixel_value, input start_of_frame, output ready);
endinterface

### design/bdu_result_if.sv
// ----------------------------------------------------------------------------
// Result pixel channel
// Valid/ready channel carrying one output pixel with its doubled-image position.
// ----------------------------------------------------------------------------
interface bdu_result_if
    import bdu_pkg::*;
#(
    parameter int PIXEL_BITS = DEF_PIXEL_BITS
);
    logic                  valid;
    logic                  ready;
    logic [COORD_W-1:0]    out_x;
    logic [COORD_W-1:0]    out_y;
    logic [PIXEL_BITS+1:0] out_value;
    logic                  last_of_run;
    logic                  frame_done;

    modport source (output valid, output out_x, output out_y, output out_value,
                    output last_of_run, output frame_done, input ready);
    modport sink   (input valid, input out_x, input out_y, input out_value,
                    input last_of_run, input frame_done, output ready);
endinterface

### design/bilinear_double_upscale.sv
// ----------------------------------------------------------------------------
// Bilinear 2x upscaler
// Streams a W x H source image in raster order and produces the (2W-1) x (2H-1)
// bilinear image in quarter units, up to one result per cycle when pix_out is
// free, tagged with its position. Results follow cell order, not raster order.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake      Payload
//  --------  ---  -------------  ----------------------------------------------
//  pix_in    in   valid/ready    pixel_value, start_of_frame
//  pix_out   out  valid/ready    out_x, out_y, out_value, last_of_run, frame_done
//  cfg       in   cfg_we only    cfg_index, cfg_data (frame_width, frame_height)
//
//  A request causes one result per set mask slot: four for an interior pixel,
//  six on the last column or the last row, nine at the bottom-right corner,
//  none on the first row or first column. The single result sequencer and the
//  one-result-per-cycle output port emit them in turn. An accepted request
//  passes the memory read, sequencer load and output register before its
//  first result shows. Reset clears only control state and held neighbors;
//  the line memory has no clearing pass and is undefined until a row has been
//  written. Stalls on pix_out back up through the sequencer and the read stage
//  to pix_in.ready; a new request is taken while earlier results still wait.
//
module bilinear_double_upscale
    import bdu_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int PIXEL_BITS = DEF_PIXEL_BITS
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  cfg_reg_t         cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    bdu_pixel_if.sink        pix_in,
    bdu_result_if.source     pix_out
);

    localparam int CNT_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int WDIM_W = $clog2(MAX_WIDTH + 1);
    localparam int HDIM_W = $clog2(MAX_HEIGHT + 1);
    localparam int WCMP_W = (WDIM_W > CFG_W) ? WDIM_W : CFG_W;
    localparam int HCMP_W = (HDIM_W > CFG_W) ? HDIM_W : CFG_W;
    localparam int VAL_W  = PIXEL_BITS + 2;
    localparam int NSLOT  = 9;

    // Result slots of one request, in emission order
    typedef enum logic [3:0] {
        SLOT_COPY        = 4'd0,
        SLOT_HALF_H      = 4'd1,
        SLOT_HALF_V      = 4'd2,
        SLOT_QUARTER     = 4'd3,
        SLOT_RIGHT_COPY  = 4'd4,
        SLOT_RIGHT_HALF  = 4'd5,
        SLOT_BOTTOM_COPY = 4'd6,
        SLOT_BOTTOM_HALF = 4'd7,
        SLOT_CORNER      = 4'd8
    } slot_t;

    // ------------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------------
    logic [CFG_W-1:0] frame_width_reg;
    logic [CFG_W-1:0] frame_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= CFG_W'(RESET_FRAME_WIDTH);
            frame_height_reg <= CFG_W'(RESET_FRAME_HEIGHT);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Saturate the sizes to 2..MAX and keep the last column and row index
    logic [CNT_W-1:0] last_col;
    logic [ROW_W-1:0] last_row;

    always_comb
    begin
        if (WCMP_W'(frame_width_reg) < WCMP_W'(2))
            last_col = CNT_W'(1);
        else if (WCMP_W'(frame_width_reg) > WCMP_W'(MAX_WIDTH))
            last_col = CNT_W'(MAX_WIDTH - 1);
        else
            last_col = CNT_W'(frame_width_reg - CFG_W'(1));

        if (HCMP_W'(frame_height_reg) < HCMP_W'(2))
            last_row = ROW_W'(1);
        else if (HCMP_W'(frame_height_reg) > HCMP_W'(MAX_HEIGHT))
            last_row = ROW_W'(MAX_HEIGHT - 1);
        else
            last_row = ROW_W'(frame_height_reg - CFG_W'(1));
    end

    // ------------------------------------------------------------------------
    // Accept stage: position, result mask, line memory read-before-write
    // ------------------------------------------------------------------------
    logic [CNT_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;
    logic [CNT_W-1:0] col_next;
    logic [ROW_W-1:0] row_next;
    logic [CNT_W-1:0] col_raw;
    logic [ROW_W-1:0] row_raw;
    logic [CNT_W-1:0] col_cur;
    logic [ROW_W-1:0] row_cur;
    logic [NSLOT-1:0] mask_s0;
    logic             cell_s0;
    logic             col_end;
    logic             row_end;
    logic             in_fire;
    logic             s1_move;

    always_comb
    begin
        col_raw = pix_in.start_of_frame ? '0 : col_reg;
        row_raw = pix_in.start_of_frame ? '0 : row_reg;
        // Pull back a position that ran past a shrunken size
        col_cur = (col_raw > last_col) ? last_col : col_raw;
        row_cur = (row_raw > last_row) ? last_row : row_raw;
        col_end = (col_cur == last_col);
        row_end = (row_cur == last_row);
        cell_s0 = (col_cur != '0) && (row_cur != '0);

        mask_s0                   = '0;
        mask_s0[SLOT_COPY]        = cell_s0;
        mask_s0[SLOT_HALF_H]      = cell_s0;
        mask_s0[SLOT_HALF_V]      = cell_s0;
        mask_s0[SLOT_QUARTER]     = cell_s0;
        mask_s0[SLOT_RIGHT_COPY]  = col_end && (row_cur != '0);
        mask_s0[SLOT_RIGHT_HALF]  = col_end && (row_cur != '0);
        mask_s0[SLOT_BOTTOM_COPY] = row_end && (col_cur != '0);
        mask_s0[SLOT_BOTTOM_HALF] = row_end && (col_cur != '0);
        mask_s0[SLOT_CORNER]      = col_end && row_end;

        if (col_end)
        begin
            col_next = '0;
            row_next = row_end ? '0 : row_cur + ROW_W'(1);
        end
        else
        begin
            col_next = col_cur + CNT_W'(1);
            row_next = row_cur;
        end
    end

    logic s1_valid_reg;

    assign pix_in.ready = !s1_valid_reg || s1_move;
    assign in_fire      = pix_in.valid && pix_in.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (in_fire)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Line memory: the read returns the previous row's pixel at this column
    // while the write replaces it with the current pixel.
    logic [PIXEL_BITS-1:0] line_mem [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] above_reg;

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            line_mem[col_cur] <= pix_in.pixel_value;
            above_reg         <= line_mem[col_cur];
        end
    end

    // Read stage holding register
    logic [PIXEL_BITS-1:0] s1_pix_reg;
    logic [CNT_W-1:0]      s1_cm1_reg;
    logic [ROW_W-1:0]      s1_rm1_reg;
    logic [CNT_W-1:0]      s1_last_col_reg;
    logic [ROW_W-1:0]      s1_last_row_reg;
    logic [NSLOT-1:0]      s1_mask_reg;

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_pix_reg      <= pix_in.pixel_value;
            s1_cm1_reg      <= col_cur - CNT_W'(1);
            s1_rm1_reg      <= row_cur - ROW_W'(1);
            s1_last_col_reg <= last_col;
            s1_last_row_reg <= last_row;
            s1_mask_reg     <= mask_s0;
        end
    end

    // ------------------------------------------------------------------------
    // Result sequencer: one result per unstalled cycle from the pending slot mask
    // ------------------------------------------------------------------------
    logic                  g_valid_reg;
    logic [NSLOT-1:0]      g_mask_reg;
    logic [PIXEL_BITS-1:0] g_pix_reg;
    logic [PIXEL_BITS-1:0] g_above_reg;
    logic [PIXEL_BITS-1:0] g_ul_reg;
    logic [PIXEL_BITS-1:0] g_left_reg;
    logic [CNT_W-1:0]      g_cm1_reg;
    logic [ROW_W-1:0]      g_rm1_reg;
    logic [CNT_W-1:0]      g_last_col_reg;
    logic [ROW_W-1:0]      g_last_row_reg;
    logic [PIXEL_BITS-1:0] ul_reg;
    logic [PIXEL_BITS-1:0] left_reg;

    logic                  o_valid_reg;
    logic                  g_fire;
    logic                  g_done;
    slot_t                 slot;
    logic [NSLOT-1:0]      g_mask_next;
    logic [VAL_W-1:0]      value_next;
    logic [COORD_W-1:0]    x_next;
    logic [COORD_W-1:0]    y_next;
    logic [CNT_W:0]        x_cell;
    logic [ROW_W:0]        y_cell;
    logic [CNT_W:0]        x_edge;
    logic [ROW_W:0]        y_edge;
    logic [VAL_W-1:0]      ul_w;
    logic [VAL_W-1:0]      ab_w;
    logic [VAL_W-1:0]      lf_w;
    logic [VAL_W-1:0]      px_w;

    // Lowest pending slot goes out first
    always_comb
    begin
        slot = SLOT_COPY;
        for (int i = NSLOT - 1; i >= 0; i--)
        begin
            if (g_mask_reg[i])
                slot = slot_t'(4'(i));
        end
    end

    assign g_mask_next = g_mask_reg & ~(NSLOT'(1) << slot);
    assign g_fire      = g_valid_reg && (!o_valid_reg || pix_out.ready);
    assign g_done      = g_fire && (g_mask_next == '0);
    assign s1_move     = s1_valid_reg && (!g_valid_reg || g_done);

    always_comb
    begin
        ul_w   = VAL_W'(g_ul_reg);
        ab_w   = VAL_W'(g_above_reg);
        lf_w   = VAL_W'(g_left_reg);
        px_w   = VAL_W'(g_pix_reg);
        x_cell = {g_cm1_reg, 1'b0};
        y_cell = {g_rm1_reg, 1'b0};
        x_edge = {g_last_col_reg, 1'b0};
        y_edge = {g_last_row_reg, 1'b0};

        case (slot)
            SLOT_COPY:
            begin
                value_next = ul_w << 2;
                x_next     = COORD_W'(x_cell);
                y_next     = COORD_W'(y_cell);
            end
            SLOT_HALF_H:
            begin
                value_next = (ul_w + ab_w) << 1;
                x_next     = COORD_W'(x_cell | (CNT_W+1)'(1));
                y_next     = COORD_W'(y_cell);
            end
            SLOT_HALF_V:
            begin
                value_next = (ul_w + lf_w) << 1;
                x_next     = COORD_W'(x_cell);
                y_next     = COORD_W'(y_cell | (ROW_W+1)'(1));
            end
            SLOT_QUARTER:
            begin
                value_next = ul_w + ab_w + lf_w + px_w;
                x_next     = COORD_W'(x_cell | (CNT_W+1)'(1));
                y_next     = COORD_W'(y_cell | (ROW_W+1)'(1));
            end
            SLOT_RIGHT_COPY:
            begin
                value_next = ab_w << 2;
                x_next     = COORD_W'(x_edge);
                y_next     = COORD_W'(y_cell);
            end
            SLOT_RIGHT_HALF:
            begin
                value_next = (ab_w + px_w) << 1;
                x_next     = COORD_W'(x_edge);
                y_next     = COORD_W'(y_cell | (ROW_W+1)'(1));
            end
            SLOT_BOTTOM_COPY:
            begin
                value_next = lf_w << 2;
                x_next     = COORD_W'(x_cell);
                y_next     = COORD_W'(y_edge);
            end
            SLOT_BOTTOM_HALF:
            begin
                value_next = (lf_w + px_w) << 1;
                x_next     = COORD_W'(x_cell | (CNT_W+1)'(1));
                y_next     = COORD_W'(y_edge);
            end
            SLOT_CORNER:
            begin
                value_next = px_w << 2;
                x_next     = COORD_W'(x_edge);
                y_next     = COORD_W'(y_edge);
            end
            default:
            begin
                value_next = '0;
                x_next     = '0;
                y_next     = '0;
            end
        endcase
    end

    // Control: stage valids, neighbor pixels, slot mask
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            g_valid_reg  <= 1'b0;
            g_mask_reg   <= '0;
            o_valid_reg  <= 1'b0;
            ul_reg       <= '0;
            left_reg     <= '0;
        end
        else
        begin
            if (in_fire)
                s1_valid_reg <= 1'b1;
            else if (s1_move)
                s1_valid_reg <= 1'b0;

            // Advance the neighbors once per request, in request order
            if (s1_move)
            begin
                ul_reg      <= above_reg;
                left_reg    <= s1_pix_reg;
                g_valid_reg <= (s1_mask_reg != '0);
                g_mask_reg  <= s1_mask_reg;
            end
            else if (g_fire)
            begin
                g_valid_reg <= !g_done;
                g_mask_reg  <= g_mask_next;
            end

            if (g_fire)
                o_valid_reg <= 1'b1;
            else if (pix_out.ready)
                o_valid_reg <= 1'b0;
        end
    end

    // Sequencer payload, loaded with the neighbors as they stand before advance
    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            g_pix_reg      <= s1_pix_reg;
            g_above_reg    <= above_reg;
            g_ul_reg       <= ul_reg;
            g_left_reg     <= left_reg;
            g_cm1_reg      <= s1_cm1_reg;
            g_rm1_reg      <= s1_rm1_reg;
            g_last_col_reg <= s1_last_col_reg;
            g_last_row_reg <= s1_last_row_reg;
        end
    end

    // ------------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------------
    logic [COORD_W-1:0] o_x_reg;
    logic [COORD_W-1:0] o_y_reg;
    logic [VAL_W-1:0]   o_value_reg;
    logic               o_last_reg;
    logic               o_done_reg;

    always_ff @(posedge clk)
    begin
        if (g_fire)
        begin
            o_x_reg     <= x_next;
            o_y_reg     <= y_next;
            o_value_reg <= value_next;
            o_last_reg  <= (g_mask_next == '0);
            o_done_reg  <= (slot == SLOT_CORNER);
        end
    end

    assign pix_out.valid       = o_valid_reg;
    assign pix_out.out_x       = o_x_reg;
    assign pix_out.out_y       = o_y_reg;
    assign pix_out.out_value   = o_value_reg;
    assign pix_out.last_of_run = o_last_reg;
    assign pix_out.frame_done  = o_done_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_seq_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        g_valid_reg |-> (g_mask_reg != '0))
        else $error("sequencer active with an empty slot mask");

    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (o_valid_reg && o_done_reg) |-> o_last_reg)
        else $error("frame_done on a result that is not the last of its request");

    a_read_held: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_move) |=> $stable(above_reg))
        else $error("line memory read data lost while the read stage stalls");

    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> s1_valid_reg)
        else $error("accepted request did not reach the read stage");

endmodule

### sim/tb_bilinear_double_upscale.sv
// ----------------------------------------------------------------------------
// Bilinear 2x upscaler testbench
// Streams directed and random source frames through the upscaler under random
// stalls on both channels, predicts every output pixel in the bench and checks
// each one, field by field, in arrival order.
// ----------------------------------------------------------------------------
module tb_bilinear_double_upscale;
    import bdu_pkg::*;

    localparam int PIX_W           = DEF_PIXEL_BITS;
    localparam int VAL_W           = PIX_W + 2;
    localparam int LINE_DEPTH      = DEF_MAX_WIDTH;
    localparam int RANDOM_REQUESTS = 250;
    localparam int PARTIAL_ROW     = 40;
    localparam int STALL_WIDTH     = 40;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int SETTLE_CYCLES   = 10;
    localparam int DRAIN_LIMIT     = 50000;
    localparam int MAX_RUN         = 80;
    localparam int TIMEOUT         = 12_000_000;

    // One output pixel of the doubled image as it leaves the block.
    typedef struct {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [VAL_W-1:0]   value;
        logic               last;
        logic               done;
    } out_pixel_t;

    // ------------------------------------------------------------------------
    // Predictor: mirrors the line buffer, the two held pixels and the raster
    // position, and queues the output pixels each source pixel must cause.
    // ------------------------------------------------------------------------
    class upscale_predictor;
        logic [PIX_W-1:0] line_mem [LINE_DEPTH];
        logic [PIX_W-1:0] left_px;
        logic [PIX_W-1:0] upper_left_px;
        int unsigned      col;
        int unsigned      row;
        logic [CFG_W-1:0] width_reg;
        logic [CFG_W-1:0] height_reg;
        out_pixel_t       pending_pixels [$];
        int               mismatches;

        function new();
            left_px       = '0;
            upper_left_px = '0;
            col           = 0;
            row           = 0;
            width_reg     = CFG_W'(RESET_FRAME_WIDTH);
            height_reg    = CFG_W'(RESET_FRAME_HEIGHT);
            mismatches    = 0;
        endfunction

        function int unsigned clamp_size(logic [CFG_W-1:0] v, int unsigned hi);
            if (v < 2)
                return 2;
            if (v > hi)
                return hi;
            return 32'(v);
        endfunction

        function int unsigned active_width();
            return clamp_size(width_reg, DEF_MAX_WIDTH);
        endfunction

        function int unsigned active_height();
            return clamp_size(height_reg, DEF_MAX_HEIGHT);
        endfunction

        function bit at_origin();
            return col == 0 && row == 0;
        endfunction

        function void write_reg(cfg_reg_t index, logic [CFG_W-1:0] data);
            case (index)
                REG_FRAME_WIDTH:  width_reg  = data;
                REG_FRAME_HEIGHT: height_reg = data;
                default: ;
            endcase
        endfunction

        function void push_px(int unsigned x, int unsigned y, int unsigned v);
            out_pixel_t e;
            e.x     = COORD_W'(x);
            e.y     = COORD_W'(y);
            e.value = VAL_W'(v);
            e.last  = 1'b0;
            e.done  = 1'b0;
            pending_pixels.push_back(e);
        endfunction

        function void take_source_pixel(logic [PIX_W-1:0] p, bit sof);
            int unsigned w;
            int unsigned h;
            int unsigned c;
            int unsigned r;
            int unsigned above;
            int unsigned ul;
            int unsigned lf;
            int unsigned pv;
            int          queued;
            w = active_width();
            h = active_height();
            if (sof)
            begin
                col = 0;
                row = 0;
            end
            // Saturate the position when the size shrank under a running frame.
            c      = (col > w - 1) ? w - 1 : col;
            r      = (row > h - 1) ? h - 1 : row;
            above  = 32'(line_mem[c]);
            ul     = 32'(upper_left_px);
            lf     = 32'(left_px);
            pv     = 32'(p);
            queued = pending_pixels.size();

            // Cell whose bottom-right corner is this pixel.
            if (c >= 1 && r >= 1)
            begin
                push_px(2*c - 2, 2*r - 2, 4*ul);
                push_px(2*c - 1, 2*r - 2, 2*(ul + above));
                push_px(2*c - 2, 2*r - 1, 2*(ul + lf));
                push_px(2*c - 1, 2*r - 1, ul + above + lf + pv);
            end
            // Right edge column.
            if (c == w - 1 && r >= 1)
            begin
                push_px(2*w - 2, 2*r - 2, 4*above);
                push_px(2*w - 2, 2*r - 1, 2*(above + pv));
            end
            // Bottom edge row.
            if (r == h - 1 && c >= 1)
            begin
                push_px(2*c - 2, 2*h - 2, 4*lf);
                push_px(2*c - 1, 2*h - 2, 2*(lf + pv));
            end
            // Bottom-right corner closes the output frame.
            if (c == w - 1 && r == h - 1)
            begin
                push_px(2*w - 2, 2*h - 2, 4*pv);
                pending_pixels[pending_pixels.size() - 1].done = 1'b1;
            end
            if (pending_pixels.size() > queued)
                pending_pixels[pending_pixels.size() - 1].last = 1'b1;

            upper_left_px = line_mem[c];
            line_mem[c]   = p;
            left_px       = p;
            if (c == w - 1)
            begin
                col = 0;
                row = (r == h - 1) ? 0 : r + 1;
            end
            else
            begin
                col = c + 1;
                row = r;
            end
        endfunction

        function void match_output_pixel(out_pixel_t got);
            out_pixel_t want;
            if (pending_pixels.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected output pixel: ",
                             "x=%0d y=%0d value=%0d last=%0b done=%0b",
                             got.x, got.y, got.value, got.last, got.done);
                mismatches++;
                return;
            end
            want = pending_pixels.pop_front();
            if (got.x !== want.x || got.y !== want.y || got.value !== want.value ||
                got.last !== want.last || got.done !== want.done)
            begin
                if (mismatches < 10)
                    $display("pixel mismatch: expected ",
                             "x=%0d y=%0d value=%0d last=%0b done=%0b",
                             want.x, want.y, want.value, want.last, want.done,
                             ", got x=%0d y=%0d value=%0d last=%0b done=%0b",
                             got.x, got.y, got.value, got.last, got.done);
                mismatches++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, configuration port and channels
    // ------------------------------------------------------------------------
    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             cfg_we    = 1'b0;
    cfg_reg_t         cfg_index = REG_FRAME_WIDTH;
    logic [CFG_W-1:0] cfg_data  = '0;

    bdu_pixel_if  #(.PIXEL_BITS(PIX_W)) pix_in_ch  ();
    bdu_result_if #(.PIXEL_BITS(PIX_W)) pix_out_ch ();

    bilinear_double_upscale #(
        .MAX_WIDTH  (DEF_MAX_WIDTH),
        .MAX_HEIGHT (DEF_MAX_HEIGHT),
        .PIXEL_BITS (PIX_W)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pix_in    (pix_in_ch),
        .pix_out   (pix_out_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    upscale_predictor model = new();

    // Idle streaks: each side draws random runs that are either calm (no gaps)
    // or busy (a random gap before each request).
    int tx_run_left   = 0;
    bit tx_calm       = 1'b1;
    int rx_run_left   = 0;
    bit rx_calm       = 1'b1;
    bit choke_request = 1'b0;

    function automatic int draw_wait(ref int run_left, ref bit calm);
        if (run_left == 0)
        begin
            calm     = ($urandom_range(0, 3) == 0);
            run_left = $urandom_range(10, 60);
        end
        run_left--;
        return calm ? 0 : $urandom_range(0, 12);
    endfunction

    // Favor black and full-scale pixels so the sums hit both ends.
    function automatic logic [PIX_W-1:0] pick_pixel();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return PIX_W'($urandom);
        endcase
    endfunction

    // Offer one source pixel after a random gap and hold it until accepted.
    // The gap keeps valid low; a zero gap keeps it high across requests.
    task automatic send_pixel(input logic [PIX_W-1:0] value, input bit sof);
        int gap;
        gap = draw_wait(tx_run_left, tx_calm);
        if (gap > 0)
        begin
            pix_in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_in_ch.valid          <= 1'b1;
        pix_in_ch.pixel_value    <= value;
        pix_in_ch.start_of_frame <= sof;
        do @(posedge clk); while (!pix_in_ch.ready);
        model.take_source_pixel(value, sof);
    endtask

    // Send a run of random pixels; with noise on, drop a stray frame start
    // into the middle now and then.
    task automatic send_random_run(input int count, input bit first_sof, input bit noisy);
        bit sof;
        for (int i = 0; i < count; i++)
        begin
            sof = (i == 0) ? first_sof : (noisy && $urandom_range(0, 29) == 0);
            send_pixel(pick_pixel(), sof);
        end
    endtask

    // Drop valid, wait for every predicted pixel plus the pipeline depth
    // (a pixel with no result may still be in flight), then write both sizes.
    task automatic resize_frame(input logic [CFG_W-1:0] width_val,
                                input logic [CFG_W-1:0] height_val);
        pix_in_ch.valid <= 1'b0;
        while (model.pending_pixels.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_FRAME_WIDTH;
        cfg_data  <= width_val;
        @(posedge clk);
        model.write_reg(REG_FRAME_WIDTH, width_val);
        cfg_index <= REG_FRAME_HEIGHT;
        cfg_data  <= height_val;
        @(posedge clk);
        model.write_reg(REG_FRAME_HEIGHT, height_val);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Result sink: random back-pressure, one long hold-off on request, and a
    // check of every accepted output pixel.
    // ------------------------------------------------------------------------
    initial
    begin : result_sink
        out_pixel_t got;
        int         wait_cycles;
        pix_out_ch.ready = 1'b0;
        @(posedge clk);
        forever
        begin
            // Hold off long enough for the block to fill and stall its input.
            if (choke_request)
            begin
                choke_request = 1'b0;
                pix_out_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            wait_cycles = draw_wait(rx_run_left, rx_calm);
            if (wait_cycles > 0)
            begin
                pix_out_ch.ready <= 1'b0;
                repeat (wait_cycles) @(posedge clk);
            end
            pix_out_ch.ready <= 1'b1;
            do @(posedge clk); while (!pix_out_ch.valid);
            got.x     = pix_out_ch.out_x;
            got.y     = pix_out_ch.out_y;
            got.value = pix_out_ch.out_value;
            got.last  = pix_out_ch.last_of_run;
            got.done  = pix_out_ch.frame_done;
            model.match_output_pixel(got);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int          random_sent;
        int          count;
        int          drain_cycles;
        int unsigned prev_width;
        bit          mid_frame;
        bit          resume;
        bit          first_sof;
        logic [CFG_W-1:0] width_val;
        logic [CFG_W-1:0] height_val;

        pix_in_ch.valid          = 1'b0;
        pix_in_ch.pixel_value    = '0;
        pix_in_ch.start_of_frame = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Start of a frame at the reset size: first row only, no results.
        send_pixel('0, 1'b1);
        send_pixel('1, 1'b0);
        send_pixel(PIX_W'(1), 1'b0);
        send_pixel(PIX_W'(16'h8000), 1'b0);

        // Shrink width mid-frame (column saturates to the last one) and push
        // height below the minimum; finish the 3x2 frame with extreme values.
        resize_frame(CFG_W'(3), CFG_W'(0));
        send_pixel('1, 1'b0);
        send_pixel('1, 1'b0);
        send_pixel('0, 1'b0);
        send_pixel('1, 1'b0);

        // Width below the minimum; the frame restarts by itself after the
        // corner, so send a full-scale 2x2 frame with no frame start.
        resize_frame(CFG_W'(1), CFG_W'(1));
        repeat (4) send_pixel('1, 1'b0);

        // Frame start in the middle of a frame restarts the position.
        send_pixel(PIX_W'(5), 1'b0);
        send_pixel(PIX_W'(6), 1'b0);
        send_pixel(PIX_W'(7), 1'b0);
        send_pixel(PIX_W'(8), 1'b1);
        send_pixel(PIX_W'(9), 1'b0);
        send_pixel(PIX_W'(10), 1'b0);
        send_pixel(PIX_W'(11), 1'b0);

        // Height above the maximum, then shrink it under the running frame
        // so the row saturates onto the last row.
        resize_frame(CFG_W'(2), '1);
        send_random_run(6, 1'b1, 1'b0);
        resize_frame(CFG_W'(2), CFG_W'(3));
        send_random_run(2, 1'b0, 1'b0);

        // Width above the maximum saturates to the widest line: a partial
        // first row, no results yet.
        resize_frame('1, CFG_W'(2));
        send_random_run(PARTIAL_ROW, 1'b1, 1'b0);

        // One full frame while the sink holds off once after its first output
        // pixel and the source keeps offering, so the block fills up.
        resize_frame(CFG_W'(STALL_WIDTH), CFG_W'(2));
        choke_request = 1'b1;
        send_random_run(2 * STALL_WIDTH, 1'b1, 1'b0);

        // Random phases.
        random_sent   = 0;
        while (random_sent < RANDOM_REQUESTS)
        begin
            case ($urandom_range(0, 9))
                0:       width_val = CFG_W'($urandom_range(0, 1));
                1:       width_val = CFG_W'($urandom_range(9, 40));
                default: width_val = CFG_W'($urandom_range(2, 8));
            endcase
            case ($urandom_range(0, 11))
                0:       height_val = CFG_W'($urandom_range(0, 1));
                1:       height_val = CFG_W'($urandom_range(1025, 2047));
                default: height_val = CFG_W'($urandom_range(2, 6));
            endcase
            prev_width = model.active_width();
            mid_frame  = !model.at_origin();
            resize_frame(width_val, height_val);

            // Resume a broken frame only if the width did not grow, so no
            // line entry is read before the previous row wrote it.
            resume = mid_frame && model.active_width() <= prev_width &&
                     $urandom_range(0, 2) == 0;
            if (resume)
                first_sof = 1'b0;
            else if (mid_frame)
                first_sof = 1'b1;
            else
                first_sof = $urandom_range(0, 1);

            count = model.active_width() * model.active_height() * $urandom_range(1, 3);
            if ($urandom_range(0, 3) == 0)
                count = $urandom_range(1, count);
            if (count > MAX_RUN)
                count = MAX_RUN;
            send_random_run(count, first_sof, 1'b1);
            random_sent += count;
        end
        pix_in_ch.valid <= 1'b0;

        // Drain the remaining output pixels, then watch for strays.
        drain_cycles = 0;
        while (model.pending_pixels.size() != 0 && drain_cycles < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain_cycles++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (model.pending_pixels.size() != 0)
            $display("output pixels never produced: %0d", model.pending_pixels.size());

        if (model.mismatches == 0 && model.pending_pixels.size() == 0)
            $display("[bilinear_double_upscale] OK");
        else
            $display("[bilinear_double_upscale] ERROR");
        $finish;
    end

    initial
    begin : watchdog
        #TIMEOUT;
        $display("[bilinear_double_upscale] ERROR");
        $finish;
    end

endmodule
